/* design/sat_pkg.sv */
// sat_pkg: shared constants, command/status types and helpers for the
// summed-area table unit; no dependencies
package sat_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned COORD_W   = 8;
    localparam int unsigned SUM_W     = 32;
    localparam int unsigned REG_W     = 9;
    localparam int unsigned CORNERS   = 4;
    localparam int unsigned IN_DATA_W = PIX_W + 2 * CORNERS * COORD_W;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_QUERY = 1'b1;

    localparam logic [REG_W-1:0] DIM_RESET = 9'd256;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;
    localparam logic [1:0] CORNER_D = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       cfg_we;
        logic       ld_rd;
        logic       ld_wr;
        logic       acc_clr;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       acc_en;
        logic       acc_sub;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic q_bad;
        logic out_free;
    } t_dp_stat;

    function automatic int unsigned clamp_dim(logic [REG_W-1:0] v, int unsigned maxv);
        int unsigned r;
        if (v == '0) begin
            r = 1;
        end else if (32'(v) > maxv) begin
            r = maxv;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic int unsigned clog2_min1(int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

/* design/sat_ram.sv */
// sat_ram: generic single-write, single-read memory with registered read
// depends on sat_pkg
module sat_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = sat_pkg::clog2_min1(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sat_ctrl.sv */
// sat_ctrl: sequencer for loads and box queries, drives datapath commands
// depends on sat_pkg
module sat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sat_pkg::t_dp_stat i_stat,
    output sat_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_RD,
        ST_Q_LAST,
        ST_Q_FIN
    } t_state;

    t_state     r_state;
    logic [1:0] r_k;
    logic       r_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= sat_pkg::CORNER_A;
            r_idle  <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_DECODE;
                        r_idle  <= 1'b0;
                    end
                end
                ST_DECODE: begin
                    r_k <= sat_pkg::CORNER_A;
                    if (!i_stat.is_query) begin
                        r_state <= ST_LD_RD;
                    end else if (i_stat.q_bad) begin
                        r_state <= ST_Q_FIN;
                    end else begin
                        r_state <= ST_Q_RD;
                    end
                end
                ST_LD_RD: begin
                    r_state <= ST_LD_WR;
                end
                ST_LD_WR: begin
                    r_state <= ST_IDLE;
                    r_idle  <= 1'b1;
                end
                ST_Q_RD: begin
                    if (r_k == sat_pkg::CORNER_D) begin
                        r_state <= ST_Q_LAST;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_Q_LAST: begin
                    r_state <= ST_Q_FIN;
                end
                ST_Q_FIN: begin
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                        r_idle  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_idle  <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                o_cmd.cfg_we  = i_cfg_valid;
            end
            ST_DECODE: begin
                o_cmd.acc_clr = 1'b1;
            end
            ST_LD_RD: begin
                o_cmd.ld_rd = 1'b1;
            end
            ST_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
            end
            ST_Q_RD: begin
                // data of the previous corner lands this cycle
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = r_k;
                o_cmd.acc_en  = (r_k != sat_pkg::CORNER_A);
                o_cmd.acc_sub = (r_k == sat_pkg::CORNER_C) || (r_k == sat_pkg::CORNER_D);
            end
            ST_Q_LAST: begin
                o_cmd.acc_en = 1'b1;
            end
            ST_Q_FIN: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_s_tready  = r_idle;
    assign o_cfg_ready = r_idle;

endmodule

/* design/sat_dp.sv */
// sat_dp: item and config registers, load counters, running row sum,
// query accumulator and output register; depends on sat_pkg
module sat_dp #(
    parameter int unsigned MAX_WIDTH  = sat_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = sat_pkg::MAX_HEIGHT_DEF,
    localparam int unsigned AW = sat_pkg::clog2_min1(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sat_pkg::t_dp_cmd                  i_cmd,
    output sat_pkg::t_dp_stat                 o_stat,
    input  logic [sat_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tuser,
    input  logic [sat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sat_pkg::REG_W-1:0]         i_cfg_data,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [sat_pkg::SUM_W-1:0]         o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_ram_we,
    output logic [AW-1:0]                     o_ram_waddr,
    output logic [sat_pkg::SUM_W-1:0]         o_ram_wdata,
    output logic                              o_ram_re,
    output logic [AW-1:0]                     o_ram_raddr,
    input  logic [sat_pkg::SUM_W-1:0]         i_ram_rdata
);

    localparam int unsigned CW  = sat_pkg::clog2_min1(MAX_WIDTH);
    localparam int unsigned RW  = sat_pkg::clog2_min1(MAX_HEIGHT);
    localparam int unsigned WDW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HDW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned SW  = sat_pkg::SUM_W;
    localparam int unsigned XW  = sat_pkg::COORD_W;

    logic [WDW-1:0] r_dim_w;
    logic [HDW-1:0] r_dim_h;
    logic [CW-1:0]  r_ld_col;
    logic [RW-1:0]  r_ld_row;
    logic [SW-1:0]  r_run;
    logic           r_out_valid;

    logic                       r_is_query;
    logic [sat_pkg::PIX_W-1:0]  r_pix;
    logic [XW-1:0]              r_row [sat_pkg::CORNERS];
    logic [XW-1:0]              r_col [sat_pkg::CORNERS];
    logic [SW-1:0]              r_acc;
    logic [SW-1:0]              r_rect;
    logic                       r_oor;

    logic [SW-1:0] n_run;
    logic [SW-1:0] above;
    logic          col_last;
    logic          row_last;
    logic          q_bad;
    logic [AW-1:0] ld_waddr;
    logic [AW-1:0] ld_raddr;
    logic [AW-1:0] q_raddr;

    // load path
    assign above    = (r_ld_row == '0) ? '0 : i_ram_rdata;
    assign n_run    = (r_ld_col == '0) ? SW'(r_pix) : r_run + SW'(r_pix);
    assign col_last = (32'(r_ld_col) + 32'd1) >= 32'(r_dim_w);
    assign row_last = (32'(r_ld_row) + 32'd1) >= 32'(r_dim_h);
    assign ld_waddr = AW'(32'(r_ld_row) * MAX_WIDTH + 32'(r_ld_col));
    assign ld_raddr = AW'((32'(r_ld_row) - 32'd1) * MAX_WIDTH + 32'(r_ld_col));
    assign q_raddr  = AW'(32'(r_row[i_cmd.rd_sel]) * MAX_WIDTH
                          + 32'(r_col[i_cmd.rd_sel]));

    assign o_ram_we    = i_cmd.ld_wr;
    assign o_ram_waddr = ld_waddr;
    assign o_ram_wdata = above + n_run;
    assign o_ram_re    = i_cmd.ld_rd | i_cmd.rd_en;
    assign o_ram_raddr = i_cmd.ld_rd ? ld_raddr : q_raddr;

    always_comb begin
        q_bad = 1'b0;
        for (int k = 0; k < sat_pkg::CORNERS; k++) begin
            if ((32'(r_row[k]) >= 32'(r_dim_h)) || (32'(r_col[k]) >= 32'(r_dim_w))) begin
                q_bad = 1'b1;
            end
        end
    end

    assign o_stat.is_query = r_is_query;
    assign o_stat.q_bad    = q_bad;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_w     <= WDW'(sat_pkg::clamp_dim(sat_pkg::DIM_RESET, MAX_WIDTH));
            r_dim_h     <= HDW'(sat_pkg::clamp_dim(sat_pkg::DIM_RESET, MAX_HEIGHT));
            r_ld_col    <= '0;
            r_ld_row    <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                unique case (i_cfg_index)
                    sat_pkg::CFG_IMAGE_WIDTH: begin
                        r_dim_w <= WDW'(sat_pkg::clamp_dim(i_cfg_data, MAX_WIDTH));
                    end
                    sat_pkg::CFG_IMAGE_HEIGHT: begin
                        r_dim_h <= HDW'(sat_pkg::clamp_dim(i_cfg_data, MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
                r_ld_col <= '0;
                r_ld_row <= '0;
                r_run    <= '0;
            end else if (i_cmd.ld_wr) begin
                r_run <= n_run;
                if (col_last) begin
                    r_ld_col <= '0;
                    r_ld_row <= row_last ? '0 : r_ld_row + RW'(1);
                end else begin
                    r_ld_col <= r_ld_col + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_query <= (i_s_tuser == sat_pkg::CMD_QUERY);
            r_pix      <= i_s_tdata[sat_pkg::PIX_W-1:0];
            for (int k = 0; k < sat_pkg::CORNERS; k++) begin
                r_row[k] <= i_s_tdata[sat_pkg::PIX_W + 2 * k * XW +: XW];
                r_col[k] <= i_s_tdata[sat_pkg::PIX_W + (2 * k + 1) * XW +: XW];
            end
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_sub ? r_acc - i_ram_rdata : r_acc + i_ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_rect <= q_bad ? '0 : r_acc;
            r_oor  <= q_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_rect;
    assign o_m_tuser  = r_oor;

endmodule

/* design/summed_area_table_with_box_query_unit.sv */
// summed-area table with box query: a load reads and then writes the table; an
// in-range query reads its corners, then waits for a free output register, a
// flagged one skips the reads; one item is in work at a time, set by the single
// read port of the table memory (one read per corner, one per loaded pixel)
// reset sets control state and image size; table holds no reset, needs no pass
// depends on sat_pkg, sat_ctrl, sat_dp, sat_ram
module summed_area_table_with_box_query_unit #(
    parameter int unsigned MAX_WIDTH  = sat_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = sat_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // pixel, a_row, a_col, b_row, b_col, c_row, c_col, d_row, d_col
    input  logic [sat_pkg::IN_DATA_W-1:0] i_s_tdata,
    // command
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // rect_sum
    output logic [sat_pkg::SUM_W-1:0]     o_m_tdata,
    // out_of_range
    output logic                          o_m_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sat_pkg::REG_W-1:0]     i_cfg_data
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = sat_pkg::clog2_min1(DEPTH);

    sat_pkg::t_dp_cmd  cmd;
    sat_pkg::t_dp_stat stat;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [sat_pkg::SUM_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [sat_pkg::SUM_W-1:0] ram_rdata;

    sat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sat_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    sat_ram #(
        .WIDTH (sat_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

/* design/sat_chk.sv */
// sat_chk: port-level checks for the summed-area table unit, bound to the top
// depends on sat_pkg and summed_area_table_with_box_query_unit
module sat_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic                      i_s_tuser,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [sat_pkg::SUM_W-1:0] o_m_tdata,
    input logic                      o_m_tuser,
    input logic                      o_cfg_ready
);

    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("flagged result carries a nonzero sum");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser && !o_m_tvalid |=> !o_m_tvalid)
        else $error("load request produced a result");

    a_busy_blocks_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready && !o_cfg_ready)
        else $error("ports ready while a request is in work");

endmodule

bind summed_area_table_with_box_query_unit sat_chk u_sat_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_cfg_ready (o_cfg_ready)
);

/* bench/testbench.sv */
// testbench for summed_area_table_with_box_query_unit: streams pixel loads and box queries
// at random pacing and checks each result against a scoreboard that keeps its own table
// depends on sat_pkg and the unit under test
typedef struct packed {
    logic [7:0] d_col;
    logic [7:0] d_row;
    logic [7:0] c_col;
    logic [7:0] c_row;
    logic [7:0] b_col;
    logic [7:0] b_row;
    logic [7:0] a_col;
    logic [7:0] a_row;
    logic [7:0] pixel;
} t_box_req;

typedef struct packed {
    logic [31:0] rect_sum;
    logic        out_of_range;
} t_box_sum;

class box_sum_scoreboard;
    localparam int unsigned PITCH = sat_pkg::MAX_WIDTH_DEF;

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    bit [31:0]   sat_mem [65536];
    bit          written [65536];
    int unsigned load_row;
    int unsigned load_col;
    bit [31:0]   run_sum;
    t_box_sum    sums_due [$];
    int          errors;
    int          loads;
    int          queries;
    int          flagged;
    int          results;

    function new();
        width_reg  = sat_pkg::DIM_RESET;
        height_reg = sat_pkg::DIM_RESET;
        restart_load();
    endfunction

    function void restart_load();
        run_sum  = '0;
        load_row = 0;
        load_col = 0;
    endfunction

    function int unsigned span(logic [8:0] v, int unsigned limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    function int unsigned img_w();
        return span(width_reg, sat_pkg::MAX_WIDTH_DEF);
    endfunction

    function int unsigned img_h();
        return span(height_reg, sat_pkg::MAX_HEIGHT_DEF);
    endfunction

    function int pending();
        return sums_due.size();
    endfunction

    function bit is_written(logic [7:0] r, logic [7:0] c);
        return written[int'(r) * PITCH + int'(c)];
    endfunction

    function bit [31:0] entry(logic [7:0] r, logic [7:0] c);
        return sat_mem[int'(r) * PITCH + int'(c)];
    endfunction

    function void set_reg(logic [sat_pkg::CFG_IDX_W-1:0] idx, logic [8:0] v);
        if (idx == sat_pkg::CFG_IMAGE_WIDTH) begin
            width_reg = v;
        end else begin
            height_reg = v;
        end
        restart_load();
    endfunction

    function void note_request(logic cmd, t_box_req req);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        bit [31:0]   above;
        logic [7:0]  rows [4];
        logic [7:0]  cols [4];
        bit          bad;
        t_box_sum    res;
        w = img_w();
        h = img_h();
        if (cmd != sat_pkg::CMD_QUERY) begin
            loads++;
            if (load_col >= w || load_row >= h) restart_load();
            if (load_col == 0) begin
                run_sum = 32'(req.pixel);
            end else begin
                run_sum += 32'(req.pixel);
            end
            above = (load_row > 0) ? sat_mem[(load_row - 1) * PITCH + load_col] : '0;
            idx = load_row * PITCH + load_col;
            sat_mem[idx] = above + run_sum;
            written[idx] = 1'b1;
            load_col++;
            if (load_col >= w) begin
                load_col = 0;
                load_row++;
                if (load_row >= h) load_row = 0;
            end
        end else begin
            queries++;
            rows = '{req.a_row, req.b_row, req.c_row, req.d_row};
            cols = '{req.a_col, req.b_col, req.c_col, req.d_col};
            bad = 1'b0;
            foreach (rows[k]) begin
                if (int'(rows[k]) >= h || int'(cols[k]) >= w) bad = 1'b1;
            end
            if (bad) begin
                flagged++;
                res.rect_sum     = '0;
                res.out_of_range = 1'b1;
            end else begin
                res.rect_sum = entry(rows[sat_pkg::CORNER_A], cols[sat_pkg::CORNER_A])
                             + entry(rows[sat_pkg::CORNER_D], cols[sat_pkg::CORNER_D])
                             - entry(rows[sat_pkg::CORNER_B], cols[sat_pkg::CORNER_B])
                             - entry(rows[sat_pkg::CORNER_C], cols[sat_pkg::CORNER_C]);
                res.out_of_range = 1'b0;
            end
            sums_due.insert(sums_due.size(), res);
        end
    endfunction

    task report(string msg);
        if (errors < 40) $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [31:0] sum, logic flag);
        t_box_sum want;
        results++;
        if (sums_due.size() == 0) begin
            report($sformatf("result sum %08h flag %0b with no query waiting", sum, flag));
            return;
        end
        want = sums_due.pop_front();
        if (flag !== want.out_of_range) begin
            report($sformatf("out_of_range %0b, expected %0b", flag, want.out_of_range));
        end
        if (sum !== want.rect_sum) begin
            report($sformatf("rect_sum %08h, expected %08h", sum, want.rect_sum));
        end
    endtask
endclass

module testbench;

    localparam logic        CMD_LOAD      = ~sat_pkg::CMD_QUERY;
    localparam int unsigned ITEM_TARGET   = 1600;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD     = 300;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [sat_pkg::IN_DATA_W-1:0] i_s_tdata   = '0;
    logic                          i_s_tuser   = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [sat_pkg::SUM_W-1:0]     o_m_tdata;
    logic                          o_m_tuser;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [sat_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sat_pkg::REG_W-1:0]     i_cfg_data  = '0;

    box_sum_scoreboard sb;
    int unsigned       items_sent = 0;
    int unsigned       burst_left = 0;
    int unsigned       shapes     = 0;
    bit                hold_req   = 1'b0;

    summed_area_table_with_box_query_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver stall pattern, with one long hold on request
    initial begin
        int unsigned mode;
        int unsigned tick;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(8, 80)) begin
                @(negedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    i_m_tready = 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                end
                tick++;
                case (mode)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = 1'($urandom_range(0, 1));
                    2: i_m_tready = ($urandom_range(0, 4) == 0);
                    default: i_m_tready = tick[1];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    function automatic t_box_req rand_req();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[sat_pkg::IN_DATA_W-1:0];
    endfunction

    function automatic t_box_req corners(input logic [7:0] ar, ac, br, bc, cr, cc, dr, dc);
        t_box_req q;
        q = rand_req();
        q.a_row = ar;
        q.a_col = ac;
        q.b_row = br;
        q.b_col = bc;
        q.c_row = cr;
        q.c_col = cc;
        q.d_row = dr;
        q.d_col = dc;
        return q;
    endfunction

    function automatic bit pick_cell(output logic [7:0] r, output logic [7:0] c);
        bit found;
        found = 1'b0;
        for (int t = 0; t < 40 && !found; t++) begin
            r = 8'($urandom_range(0, sb.img_h() - 1));
            c = 8'($urandom_range(0, sb.img_w() - 1));
            found = sb.is_written(r, c);
        end
        return found;
    endfunction

    // well-formed box in three of four tries when the corners allow it, else four loose written corners
    function automatic bit build_box(output t_box_req q);
        logic [7:0] r0, c0, r1, c1, rl, rh, cl, ch;
        q = rand_req();
        if (!pick_cell(r0, c0) || !pick_cell(r1, c1)) return 1'b0;
        rl = (r0 < r1) ? r0 : r1;
        rh = (r0 < r1) ? r1 : r0;
        cl = (c0 < c1) ? c0 : c1;
        ch = (c0 < c1) ? c1 : c0;
        if ($urandom_range(0, 3) != 0 && sb.is_written(rh, ch) && sb.is_written(rl, cl)
                && sb.is_written(rl, ch) && sb.is_written(rh, cl)) begin
            q = corners(rh, ch, rl, ch, rh, cl, rl, cl);
            return 1'b1;
        end
        q.a_row = r0;
        q.a_col = c0;
        q.d_row = r1;
        q.d_col = c1;
        return pick_cell(q.b_row, q.b_col) && pick_cell(q.c_row, q.c_col);
    endfunction

    function automatic bit build_flagged(output t_box_req q);
        int unsigned w;
        int unsigned h;
        bit          use_row;
        logic [7:0]  bad;
        w = sb.img_w();
        h = sb.img_h();
        q = rand_req();
        if (w == sat_pkg::MAX_WIDTH_DEF && h == sat_pkg::MAX_HEIGHT_DEF) return 1'b0;
        use_row = (h < sat_pkg::MAX_HEIGHT_DEF)
                  && (w == sat_pkg::MAX_WIDTH_DEF || $urandom_range(0, 1) == 1);
        bad = use_row ? 8'($urandom_range(h, 255)) : 8'($urandom_range(w, 255));
        case (2'($urandom_range(0, 3)))
            sat_pkg::CORNER_A: if (use_row) q.a_row = bad; else q.a_col = bad;
            sat_pkg::CORNER_B: if (use_row) q.b_row = bad; else q.b_col = bad;
            sat_pkg::CORNER_C: if (use_row) q.c_row = bad; else q.c_col = bad;
            default:           if (use_row) q.d_row = bad; else q.d_col = bad;
        endcase
        return 1'b1;
    endfunction

    task automatic send_item(input logic cmd, input t_box_req q);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6)) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                i_s_tdata = rand_req();
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser = cmd;
        i_s_tdata = q;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(cmd, q);
        items_sent++;
    endtask

    task automatic load_px(input logic [7:0] p);
        t_box_req q;
        q = rand_req();
        q.pixel = p;
        send_item(CMD_LOAD, q);
    endtask

    task automatic send_load();
        case ($urandom_range(0, 7))
            0: load_px(8'hFF);
            1: load_px(8'h00);
            default: load_px(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_query();
        t_box_req q;
        if ($urandom_range(0, 6) == 0 && build_flagged(q)) begin
            send_item(sat_pkg::CMD_QUERY, q);
        end else if (build_box(q)) begin
            send_item(sat_pkg::CMD_QUERY, q);
        end else if (build_flagged(q)) begin
            send_item(sat_pkg::CMD_QUERY, q);
        end else begin
            send_load();
        end
    endtask

    // sender goes quiet until every result is back and the last load has retired
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [sat_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sat_pkg::REG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_shape(input logic [sat_pkg::REG_W-1:0] w,
                             input logic [sat_pkg::REG_W-1:0] h);
        settle();
        if ($urandom_range(0, 1) == 1) begin
            write_cfg(sat_pkg::CFG_IMAGE_WIDTH, w);
            write_cfg(sat_pkg::CFG_IMAGE_HEIGHT, h);
        end else begin
            write_cfg(sat_pkg::CFG_IMAGE_HEIGHT, h);
            write_cfg(sat_pkg::CFG_IMAGE_WIDTH, w);
        end
    endtask

    task automatic directed();
        // reset shape, a few pixels on row 0
        load_px(8'hFF);
        load_px(8'h00);
        load_px(8'h80);
        load_px(8'h01);
        send_item(sat_pkg::CMD_QUERY, corners(0, 3, 0, 1, 0, 2, 0, 0));
        send_item(sat_pkg::CMD_QUERY, corners(0, 0, 0, 0, 0, 0, 0, 0));
        // zero width acts as one column, load wraps past the last row
        set_shape(9'd0, 9'd3);
        repeat (5) load_px(8'hFF);
        send_item(sat_pkg::CMD_QUERY, corners(2, 0, 0, 0, 1, 0, 2, 0));
        send_item(sat_pkg::CMD_QUERY, corners(8'hFF, 0, 0, 0, 0, 0, 0, 0));
        send_item(sat_pkg::CMD_QUERY, corners(0, 0, 0, 8'hFF, 0, 0, 0, 0));
        send_item(sat_pkg::CMD_QUERY,
                  corners(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // register write in the middle of an image restarts the load
        set_shape(9'd2, 9'd2);
        repeat (3) load_px(8'h55);
        settle();
        write_cfg(sat_pkg::CFG_IMAGE_HEIGHT, 9'd2);
        load_px(8'h7F);
        load_px(8'hFF);
        load_px(8'h80);
        load_px(8'h01);
        send_item(sat_pkg::CMD_QUERY, corners(1, 1, 0, 1, 1, 0, 0, 0));
        send_item(sat_pkg::CMD_QUERY, corners(1, 1, 1, 1, 1, 1, 1, 1));
    endtask

    task automatic run_image(input logic [sat_pkg::REG_W-1:0] w,
                             input logic [sat_pkg::REG_W-1:0] h);
        int unsigned n;
        set_shape(w, h);
        shapes++;
        n = sb.img_w() * sb.img_h();
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 20) send_query();
            send_load();
        end
        repeat ($urandom_range(3, 12)) send_query();
    endtask

    task automatic random_image();
        logic [sat_pkg::REG_W-1:0] w;
        logic [sat_pkg::REG_W-1:0] h;
        case ($urandom_range(0, 11))
            0: begin
                w = 9'($urandom_range(0, 511));
                h = 9'($urandom_range(0, 2));
            end
            1: begin
                w = 9'($urandom_range(0, 2));
                h = 9'($urandom_range(0, 511));
            end
            default: begin
                w = 9'($urandom_range(1, 12));
                h = 9'($urandom_range(1, 12));
            end
        endcase
        run_image(w, h);
    endtask

    // output held off while queries keep coming, then a full drain mid-stream
    task automatic pressure();
        hold_req = 1'b1;
        repeat (10) send_query();
        settle();
        repeat (6) send_query();
    endtask

    initial begin
        sb = new();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        directed();
        run_image(9'd256, 9'd1);
        pressure();
        run_image(9'd1, 9'd256);
        run_image(9'd511, 9'd1);
        run_image(9'd2, 9'd300);
        run_image(9'd0, 9'd0);
        while (items_sent < ITEM_TARGET) random_image();
        settle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d pixel loads and %0d box queries, %0d of them out of range",
                 sb.loads, sb.queries, sb.flagged);
        $display("over %0d image shapes; %0d results checked, %0d mismatches",
                 shapes, sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

/* files.f */
design/sat_pkg.sv
design/sat_ram.sv
design/sat_ctrl.sv
design/sat_dp.sv
design/summed_area_table_with_box_query_unit.sv
design/sat_chk.sv
bench/testbench.sv
